// ===== rtl/fqp_pkg.sv =====
// Shared types and constants of the FASTQ record parser.
package fqp_pkg;

    localparam int MAX_NAME_DEF = 64;
    localparam int LEN_BITS_DEF = 16;
    localparam int MODE_W       = 2;

    typedef logic [7:0]        t_byte;
    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [4:0]        t_errs;

    localparam logic KIND_SCORE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Quality encodings selected by format_mode; the spare code decodes as the first.
    localparam t_mode MODE_SANGER   = 2'd0;
    localparam t_mode MODE_ILLUMINA = 2'd1;
    localparam t_mode MODE_SOLEXA   = 2'd2;
    localparam t_mode MODE_SPARE    = 2'd3;

    localparam t_errs ERR_NO_AT     = 5'b00001;
    localparam t_errs ERR_NO_PLUS   = 5'b00010;
    localparam t_errs ERR_NAME_DIFF = 5'b00100;
    localparam t_errs ERR_LEN_DIFF  = 5'b01000;
    localparam t_errs ERR_NAME_LONG = 5'b10000;

    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_NL    = 8'h0A;
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_PLUS  = 8'h2B;
    localparam t_byte CH_AT    = 8'h40;

    // One operation handed from the parser to the result stage.
    typedef struct packed {
        logic        kind;
        t_byte       data;
        logic [15:0] seq_length;
        t_errs       errors;
    } t_op;

endpackage

// ===== rtl/fqp_if.sv =====
// Valid/ready channel interfaces for the byte input and the result output.
interface fqp_in_if;
    logic            valid;
    logic            ready;
    fqp_pkg::t_byte  in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface fqp_out_if;
    logic            valid;
    logic            ready;
    logic            result_kind;
    fqp_pkg::t_byte  score;
    logic [15:0]     seq_length;
    fqp_pkg::t_errs  error_bits;
    logic            record_ignored;
    logic            negative_seen;

    modport source (output valid, output result_kind, output score, output seq_length,
                    output error_bits, output record_ignored, output negative_seen,
                    input ready);
    modport sink   (input valid, input result_kind, input score, input seq_length,
                    input error_bits, input record_ignored, input negative_seen,
                    output ready);
endinterface

// ===== rtl/fastq_record_parser.sv =====
// FASTQ record parser: takes one text byte per clock request and emits one result per
// quality byte plus a summary with error bits at the end of each four-line record,
// at one byte per clock while the output does not stall; a byte is taken in the same
// cycle it is offered whenever the two-entry queue in front of the result register has
// room, and its result reaches the output through that queue and the result register.
// The '+' name check reads the name RAM as the byte is taken, compares in the cycle
// after and folds a mismatch into the error bits. The name RAM needs no clearing after
// reset. Write format_mode via i_cfg_we/i_cfg_wdata while the block is idle; unchecked.
module fastq_record_parser #(
    parameter int MAX_NAME = fqp_pkg::MAX_NAME_DEF,
    parameter int LEN_BITS = fqp_pkg::LEN_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  fqp_pkg::t_mode i_cfg_wdata,
    fqp_in_if.sink         i_in,
    fqp_out_if.source      o_out
);

    logic         push;
    fqp_pkg::t_op push_op;
    logic         q_ready;
    logic         q_valid;
    fqp_pkg::t_op q_op;
    logic         q_pop;

    fqp_front #(
        .MAX_NAME (MAX_NAME),
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_op      (push_op)
    );

    fqp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (q_pop)
    );

    fqp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_op      (q_op),
        .o_q_pop     (q_pop),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/fqp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fqp_queue.sv =====
// Two-entry queue between the parser and the result stage.
module fqp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fqp_pkg::t_op  i_op,
    output logic          o_ready,
    output logic          o_valid,
    output fqp_pkg::t_op  o_op,
    input  logic          i_pop
);

    fqp_pkg::t_op r_ent [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_ent[r_rd_ptr];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_ent[r_wr_ptr] <= i_op;
                r_wr_ptr        <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/fqp_front.sv =====
// Record parser: phase tracking, name store, record checks and operation issue.
module fqp_front #(
    parameter int MAX_NAME = fqp_pkg::MAX_NAME_DEF,
    parameter int LEN_BITS = fqp_pkg::LEN_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fqp_in_if.sink        i_in,
    input  logic          i_q_ready,
    output logic          o_push,
    output fqp_pkg::t_op  o_op
);

    localparam int AW = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
    localparam int NW = $clog2(MAX_NAME + 1);
    localparam int CW = $clog2(MAX_NAME + 2);
    localparam int EW = (LEN_BITS > 16) ? LEN_BITS : 16;

    localparam logic [LEN_BITS-1:0] CNT_MAX = {LEN_BITS{1'b1}};

    typedef enum logic [3:0] {
        PH_NAME_WS, PH_NAME_TOK, PH_NAME_REST, PH_SEQ_WS, PH_SEQ,
        PH_PLUS_WS, PH_PLUS_TOK, PH_PLUS_REST, PH_QUAL_WS, PH_QUAL
    } t_phase;

    t_phase              r_phase,      n_phase;
    logic [NW-1:0]       r_name_len,   n_name_len;
    logic [CW-1:0]       r_cmp_idx,    n_cmp_idx;
    logic                r_plus_empty, n_plus_empty;
    logic [LEN_BITS-1:0] r_seq_cnt,    n_seq_cnt;
    logic [LEN_BITS-1:0] r_qual_cnt,   n_qual_cnt;
    fqp_pkg::t_errs      r_errs,       n_errs;
    logic                r_cmp_vld,    n_cmp_vld;
    fqp_pkg::t_byte      r_cmp_byte,   n_cmp_byte;

    logic                acc;
    fqp_pkg::t_byte      b;
    logic                nl;
    logic                ws;
    logic                name_put;
    logic                plus_put;
    logic [CW-1:0]       plus_idx;
    fqp_pkg::t_errs      base_errs;
    logic [EW-1:0]       seq_ext;
    logic [15:0]         seq16;
    logic                ram_we;
    logic                ram_re;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    fqp_pkg::t_byte      ram_rdata;

    assign i_in.ready = i_q_ready;
    assign acc        = i_in.valid && i_q_ready;
    assign b          = i_in.in_byte;
    assign nl         = (b == fqp_pkg::CH_NL);
    assign ws         = (b == fqp_pkg::CH_SPACE) ||
                        ((b >= fqp_pkg::CH_TAB) && (b <= fqp_pkg::CH_CR));
    assign ram_waddr  = r_name_len[AW-1:0];
    assign ram_raddr  = plus_idx[AW-1:0];
    assign seq_ext    = EW'(r_seq_cnt);
    assign seq16      = (seq_ext > EW'(16'hFFFF)) ? 16'hFFFF : seq_ext[15:0];

    fqp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_NAME)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (b),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_phase      = r_phase;
        n_name_len   = r_name_len;
        n_cmp_idx    = r_cmp_idx;
        n_plus_empty = r_plus_empty;
        n_seq_cnt    = r_seq_cnt;
        n_qual_cnt   = r_qual_cnt;
        n_cmp_vld    = 1'b0;
        n_cmp_byte   = r_cmp_byte;
        name_put     = 1'b0;
        plus_put     = 1'b0;
        plus_idx     = r_cmp_idx;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        o_push       = 1'b0;
        o_op         = '{kind: fqp_pkg::KIND_SCORE, data: b, seq_length: 16'd0,
                         errors: 5'd0};

        // The name byte read for the previous byte of the '+' line is compared here.
        base_errs = r_errs;
        if (r_cmp_vld && (ram_rdata != r_cmp_byte)) begin
            base_errs = base_errs | fqp_pkg::ERR_NAME_DIFF;
        end
        n_errs = base_errs;

        if (acc) begin
            unique case (r_phase) inside
                PH_NAME_WS: begin
                    if (!ws) begin
                        if (b != fqp_pkg::CH_AT) begin
                            n_errs   = n_errs | fqp_pkg::ERR_NO_AT;
                            name_put = 1'b1;
                        end
                        n_phase = PH_NAME_TOK;
                    end
                end
                PH_NAME_TOK: begin
                    if (nl) begin
                        n_phase = PH_SEQ_WS;
                    end else if (ws) begin
                        n_phase = PH_NAME_REST;
                    end else begin
                        name_put = 1'b1;
                    end
                end
                PH_NAME_REST: begin
                    if (nl) begin
                        n_phase = PH_SEQ_WS;
                    end
                end
                PH_SEQ_WS: begin
                    if (!ws) begin
                        n_phase = PH_SEQ;
                        if (r_seq_cnt != CNT_MAX) begin
                            n_seq_cnt = r_seq_cnt + 1'b1;
                        end
                    end
                end
                PH_SEQ: begin
                    if (nl) begin
                        n_phase = PH_PLUS_WS;
                    end else if (r_seq_cnt != CNT_MAX) begin
                        n_seq_cnt = r_seq_cnt + 1'b1;
                    end
                end
                PH_PLUS_WS: begin
                    if (!ws) begin
                        n_cmp_idx    = '0;
                        n_plus_empty = 1'b1;
                        plus_idx     = '0;
                        if (b != fqp_pkg::CH_PLUS) begin
                            n_errs   = n_errs | fqp_pkg::ERR_NO_PLUS;
                            plus_put = 1'b1;
                        end
                        n_phase = PH_PLUS_TOK;
                    end
                end
                PH_PLUS_TOK: begin
                    if (ws) begin
                        if (!r_plus_empty && (r_cmp_idx != CW'(r_name_len))) begin
                            n_errs = n_errs | fqp_pkg::ERR_NAME_DIFF;
                        end
                        n_phase = nl ? PH_QUAL_WS : PH_PLUS_REST;
                    end else begin
                        plus_put = 1'b1;
                    end
                end
                PH_PLUS_REST: begin
                    if (nl) begin
                        n_phase = PH_QUAL_WS;
                    end
                end
                PH_QUAL_WS, PH_QUAL: begin
                    if ((r_phase == PH_QUAL) && nl) begin
                        o_push = 1'b1;
                        o_op.kind       = fqp_pkg::KIND_SUMMARY;
                        o_op.data       = 8'd0;
                        o_op.seq_length = seq16;
                        o_op.errors     = base_errs |
                                          ((r_qual_cnt != r_seq_cnt) ?
                                           fqp_pkg::ERR_LEN_DIFF : 5'd0);
                        n_phase      = PH_NAME_WS;
                        n_name_len   = '0;
                        n_cmp_idx    = '0;
                        n_plus_empty = 1'b1;
                        n_seq_cnt    = '0;
                        n_qual_cnt   = '0;
                        n_errs       = '0;
                    end else if ((r_phase == PH_QUAL) || !ws) begin
                        o_push  = 1'b1;
                        n_phase = PH_QUAL;
                        if (r_qual_cnt != CNT_MAX) begin
                            n_qual_cnt = r_qual_cnt + 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_NAME_WS;
                end
            endcase
        end

        if (name_put) begin
            if (r_name_len < NW'(MAX_NAME)) begin
                ram_we     = 1'b1;
                n_name_len = r_name_len + 1'b1;
            end else begin
                n_errs = n_errs | fqp_pkg::ERR_NAME_LONG;
            end
        end

        if (plus_put) begin
            n_plus_empty = 1'b0;
            if (plus_idx >= CW'(r_name_len)) begin
                n_errs = n_errs | fqp_pkg::ERR_NAME_DIFF;
            end else begin
                ram_re     = 1'b1;
                n_cmp_vld  = 1'b1;
                n_cmp_byte = b;
            end
            if (plus_idx < CW'(MAX_NAME + 1)) begin
                n_cmp_idx = plus_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_NAME_WS;
            r_name_len   <= '0;
            r_cmp_idx    <= '0;
            r_plus_empty <= 1'b1;
            r_seq_cnt    <= '0;
            r_qual_cnt   <= '0;
            r_errs       <= '0;
            r_cmp_vld    <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_name_len   <= n_name_len;
            r_cmp_idx    <= n_cmp_idx;
            r_plus_empty <= n_plus_empty;
            r_seq_cnt    <= n_seq_cnt;
            r_qual_cnt   <= n_qual_cnt;
            r_errs       <= n_errs;
            r_cmp_vld    <= n_cmp_vld;
        end
        r_cmp_byte <= n_cmp_byte;
    end

endmodule

// ===== rtl/fqp_back.sv =====
// Result stage: quality conversion, negative tracking and the output register.
module fqp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  fqp_pkg::t_mode i_cfg_wdata,
    input  logic           i_q_valid,
    input  fqp_pkg::t_op   i_q_op,
    output logic           o_q_pop,
    fqp_out_if.source      o_out
);

    // Solexa odds scale mapped to phred, in terms of the raw byte (offset 64).
    function automatic fqp_pkg::t_byte solexa_score(input fqp_pkg::t_byte byte_in);
        fqp_pkg::t_byte s;
        if (byte_in <= 8'd54) begin
            s = 8'd0;
        end else if (byte_in <= 8'd60) begin
            s = 8'd1;
        end else if (byte_in <= 8'd62) begin
            s = 8'd2;
        end else if (byte_in <= 8'd64) begin
            s = 8'd3;
        end else if (byte_in <= 8'd66) begin
            s = 8'd4;
        end else if (byte_in <= 8'd68) begin
            s = 8'd5;
        end else if (byte_in <= 8'd73) begin
            s = byte_in - 8'd63;
        end else begin
            s = byte_in - 8'd64;
        end
        return s;
    endfunction

    fqp_pkg::t_mode r_mode;
    logic           r_vld;
    logic           r_neg;
    logic           r_kind;
    fqp_pkg::t_byte r_score;
    logic [15:0]    r_seq_len;
    fqp_pkg::t_errs r_errs;
    logic           r_ignored;
    logic           r_neg_out;

    logic           pop;
    logic [8:0]     diff;
    logic           neg;
    fqp_pkg::t_byte score;

    assign pop     = i_q_valid && (!r_vld || o_out.ready);
    assign o_q_pop = pop;

    always_comb begin
        diff  = 9'd0;
        neg   = 1'b0;
        score = 8'd0;
        case (r_mode)
            fqp_pkg::MODE_ILLUMINA: begin
                diff  = {1'b0, i_q_op.data} - 9'd64;
                neg   = diff[8];
                score = neg ? 8'd0 : diff[7:0];
            end
            fqp_pkg::MODE_SOLEXA: begin
                score = solexa_score(i_q_op.data);
            end
            default: begin
                diff  = {1'b0, i_q_op.data} - 9'd33;
                neg   = diff[8];
                score = neg ? 8'd0 : diff[7:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= fqp_pkg::MODE_SANGER;
            r_vld  <= 1'b0;
            r_neg  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (pop) begin
                r_vld  <= 1'b1;
                r_kind <= i_q_op.kind;
                if (i_q_op.kind == fqp_pkg::KIND_SUMMARY) begin
                    r_score   <= 8'd0;
                    r_seq_len <= i_q_op.seq_length;
                    r_errs    <= i_q_op.errors;
                    r_ignored <= |i_q_op.errors;
                    r_neg_out <= r_neg;
                    r_neg     <= 1'b0;
                end else begin
                    r_score   <= score;
                    r_seq_len <= 16'd0;
                    r_errs    <= 5'd0;
                    r_ignored <= 1'b0;
                    r_neg_out <= 1'b0;
                    r_neg     <= r_neg | neg;
                end
            end else if (o_out.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_vld;
    assign o_out.result_kind    = r_kind;
    assign o_out.score          = r_score;
    assign o_out.seq_length     = r_seq_len;
    assign o_out.error_bits     = r_errs;
    assign o_out.record_ignored = r_ignored;
    assign o_out.negative_seen  = r_neg_out;

endmodule
